>>> rtl/core/scad_pkg.sv
// Shared types and constants for the share check and adaptive difficulty unit.
// No dependencies; every other file of the block imports this package.
package scad_pkg;

    localparam int TIME_BITS   = 32;
    localparam int HASH_W      = 256;
    localparam int WORD_W      = 64;
    localparam int LEVEL_W     = 3;
    localparam int INTERVAL_W  = 29;
    localparam int THIRD_W     = 28;
    localparam int TWICE_W     = 30;
    localparam int TEN_W       = 33;
    localparam int CFG_IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL   = 3'd5;
    localparam logic [LEVEL_W-1:0] FLOOR_LEVEL = 3'd3;

    localparam logic [LEVEL_W-1:0]    BASE_LEVEL_RST     = 3'd1;
    localparam logic [INTERVAL_W-1:0] SHARE_INTERVAL_RST = 29'd60000;
    localparam logic [TIME_BITS-1:0]  ADJUST_PERIOD_RST  = 32'd60000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_ENABLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_PERIOD = 3'd7;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_INIT   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CHG_NONE = 2'd0,
        CHG_DOWN = 2'd1,
        CHG_UP   = 2'd2
    } t_change;

    // Configuration as seen by the datapath, with interval multiples precomputed.
    typedef struct packed {
        logic [HASH_W-1:0]     target;
        logic [LEVEL_W-1:0]    base_level;
        logic [THIRD_W-1:0]    third;
        logic [TWICE_W-1:0]    twice;
        logic [TEN_W-1:0]      ten;
        logic                  adapt_enable;
        logic [TIME_BITS-1:0]  adjust_period;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [TIME_BITS-1:0] now_time;
        logic [HASH_W-1:0]    hash;
    } t_item;

    typedef struct packed {
        logic               half_share;
        logic               share_found;
        logic               meets_target;
        logic [LEVEL_W-1:0] level_now;
        logic [1:0]         level_change;
        logic               timer_restarted;
    } t_result;

endpackage

>>> rtl/core/scad_in_if.sv
// Input channel of the share check unit: one operation per beat.
// Depends on scad_pkg for field widths.
interface scad_in_if;
    import scad_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [TIME_BITS-1:0] now_time;
    logic [WORD_W-1:0]    hash_word0;
    logic [WORD_W-1:0]    hash_word1;
    logic [WORD_W-1:0]    hash_word2;
    logic [WORD_W-1:0]    hash_word3;

    modport source (
        output valid, opcode, now_time, hash_word0, hash_word1, hash_word2, hash_word3,
        input  ready
    );
    modport sink (
        input  valid, opcode, now_time, hash_word0, hash_word1, hash_word2, hash_word3,
        output ready
    );
endinterface

>>> rtl/core/scad_out_if.sv
// Result channel of the share check unit: one result per beat.
// Depends on scad_pkg for field widths.
interface scad_out_if;
    import scad_pkg::*;

    logic               valid;
    logic               ready;
    logic               half_share;
    logic               share_found;
    logic               meets_target;
    logic [LEVEL_W-1:0] level_now;
    logic [1:0]         level_change;
    logic               timer_restarted;

    modport source (
        output valid, half_share, share_found, meets_target, level_now, level_change,
               timer_restarted,
        input  ready
    );
    modport sink (
        input  valid, half_share, share_found, meets_target, level_now, level_change,
               timer_restarted,
        output ready
    );
endinterface

>>> rtl/core/scad_cfg.sv
// Configuration register file with precomputed share interval multiples.
// Depends on scad_pkg.
module scad_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [scad_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scad_pkg::WORD_W-1:0]    i_cfg_data,
    output scad_pkg::t_cfg                 o_cfg
);
    import scad_pkg::*;

    // Division by three as a multiply by the rounded-up reciprocal 2^33/3.
    function automatic logic [THIRD_W-1:0] f_third(input logic [INTERVAL_W-1:0] x);
        logic [60:0] prod;
        prod = 61'(x) * 61'(32'hAAAA_AAAB);
        return prod[60:33];
    endfunction

    function automatic logic [TEN_W-1:0] f_ten(input logic [INTERVAL_W-1:0] x);
        return (TEN_W'(x) << 3) + (TEN_W'(x) << 1);
    endfunction

    t_cfg r_cfg;
    logic [INTERVAL_W-1:0] w_interval;

    assign w_interval = i_cfg_data[INTERVAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target        <= '0;
            r_cfg.base_level    <= BASE_LEVEL_RST;
            r_cfg.third         <= f_third(SHARE_INTERVAL_RST);
            r_cfg.twice         <= {SHARE_INTERVAL_RST, 1'b0};
            r_cfg.ten           <= f_ten(SHARE_INTERVAL_RST);
            r_cfg.adapt_enable  <= 1'b1;
            r_cfg.adjust_period <= ADJUST_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET0:        r_cfg.target[63:0]    <= i_cfg_data;
                CFG_TARGET1:        r_cfg.target[127:64]  <= i_cfg_data;
                CFG_TARGET2:        r_cfg.target[191:128] <= i_cfg_data;
                CFG_TARGET3:        r_cfg.target[255:192] <= i_cfg_data;
                CFG_BASE_LEVEL:     r_cfg.base_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_SHARE_INTERVAL: begin
                    r_cfg.third <= f_third(w_interval);
                    r_cfg.twice <= {w_interval, 1'b0};
                    r_cfg.ten   <= f_ten(w_interval);
                end
                CFG_ADAPT_ENABLE:   r_cfg.adapt_enable <= i_cfg_data[0];
                CFG_ADJUST_PERIOD:  r_cfg.adjust_period <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> rtl/core/scad_hash_chk.sv
// Hash qualification: half-share, share at the current level, and target compare.
// Depends on scad_pkg.
module scad_hash_chk (
    input  logic [scad_pkg::HASH_W-1:0]  i_hash,
    input  logic [scad_pkg::HASH_W-1:0]  i_target,
    input  logic [scad_pkg::LEVEL_W-1:0] i_level,
    output logic                         o_half_share,
    output logic                         o_share_found,
    output logic                         o_meets_target
);
    import scad_pkg::*;

    logic [7:0] w_byte_ok;

    // Byte j counts from the most significant byte; the top level+1 bytes must be zero.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_byte_ok[j] = (4'(j) > {1'b0, i_level}) || (i_hash[HASH_W-1-8*j -: 8] == 8'd0);
        end
    end

    assign o_half_share   = (i_hash[HASH_W-1 -: 16] == 16'd0);
    assign o_share_found  = &w_byte_ok;
    assign o_meets_target = (i_hash <= i_target);
endmodule

>>> rtl/core/scad_adapt.sv
// Difficulty level and share/adjust timestamps with the adaptation rule.
// Depends on scad_pkg; the state advances once for every item processed.
module scad_adapt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [1:0]                     i_opcode,
    input  logic [scad_pkg::TIME_BITS-1:0] i_now,
    input  logic                           i_share,
    input  scad_pkg::t_cfg                 i_cfg,
    output logic [scad_pkg::LEVEL_W-1:0]   o_level,
    output logic [scad_pkg::LEVEL_W-1:0]   o_level_now,
    output logic [1:0]                     o_level_change,
    output logic                           o_timer_restarted
);
    import scad_pkg::*;

    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [TIME_BITS-1:0] r_share_stamp, n_share_stamp;
    logic [TIME_BITS-1:0] r_adjust_stamp, n_adjust_stamp;

    logic [TIME_BITS-1:0] w_since, w_since_adj;
    logic [LEVEL_W-1:0]   w_floor;
    t_change              w_change;
    logic                 w_restart;

    assign w_since     = i_now - r_share_stamp;
    assign w_since_adj = i_now - r_adjust_stamp;
    assign w_floor     = (i_cfg.base_level > FLOOR_LEVEL) ? i_cfg.base_level : FLOOR_LEVEL;

    always_comb begin
        n_level        = r_level;
        n_share_stamp  = r_share_stamp;
        n_adjust_stamp = r_adjust_stamp;
        w_change       = CHG_NONE;
        w_restart      = 1'b0;
        case (t_opcode'(i_opcode))
            OP_CHECK: begin
                if (i_share) begin
                    w_restart = 1'b1;
                end
            end
            OP_UPDATE: begin
                if (i_cfg.adapt_enable && (w_since_adj >= i_cfg.adjust_period)) begin
                    n_adjust_stamp = i_now;
                    if ((TEN_W'(w_since) > TEN_W'(i_cfg.twice)) && (r_level > w_floor)) begin
                        n_level   = r_level - 3'd1;
                        w_change  = CHG_DOWN;
                        w_restart = 1'b1;
                    end else if ((w_since < TIME_BITS'(i_cfg.third)) &&
                                 (r_level < MAX_LEVEL)) begin
                        n_level   = r_level + 3'd1;
                        w_change  = CHG_UP;
                        w_restart = 1'b1;
                    end
                    if (TEN_W'(w_since) > i_cfg.ten) begin
                        w_restart = 1'b1;
                    end
                end
            end
            OP_INIT: begin
                n_level   = i_cfg.base_level;
                w_restart = 1'b1;
            end
            default: ;
        endcase
        if (w_restart) begin
            n_share_stamp = i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= BASE_LEVEL_RST;
            r_share_stamp  <= '0;
            r_adjust_stamp <= '0;
        end else if (i_fire) begin
            r_level        <= n_level;
            r_share_stamp  <= n_share_stamp;
            r_adjust_stamp <= n_adjust_stamp;
        end
    end

    assign o_level           = r_level;
    assign o_level_now       = n_level;
    assign o_level_change    = w_change;
    assign o_timer_restarted = w_restart;
endmodule

>>> rtl/core/share_check_adaptive_difficulty_unit.sv
// Share check and adaptive difficulty unit, top level.
// Depends on scad_pkg, scad_in_if, scad_out_if, scad_cfg, scad_hash_chk, scad_adapt.
//
// Usage:
//   Each beat on the input channel carries one operation: a hash check, a
//   difficulty update or a difficulty init, with the current timestamp and
//   the 256-bit hash. Every operation yields exactly one beat on the result
//   channel with the check flags, the level after the operation, the level
//   change code and whether the share timer was restarted.
//   The configuration port takes one register write per cycle with write enable
//   high; the user must write it only while no operation is in flight (unchecked).
// Pipeline and throughput:
//   A beat is captured in an input register, evaluated combinationally
//   against the current level and timestamps, and the result lands in
//   an output register. The difficulty state is updated in the same
//   cycle the result is formed, so the next operation sees it, and one
//   operation is accepted per cycle while the receiver keeps ready high.
// Reset and stall:
//   Synchronous reset clears both pipeline stages and loads the register
//   reset values: level 1, both timestamps zero, target zero. When the
//   receiver holds ready low the result stays put, the input register fills
//   once more and then input ready drops until the result is taken.
module share_check_adaptive_difficulty_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    scad_in_if.sink                        i_in_ch,
    scad_out_if.source                     o_out_ch,
    input  logic                           i_cfg_we,
    input  logic [scad_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scad_pkg::WORD_W-1:0]    i_cfg_data
);
    import scad_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_result;
    logic    r_out_valid;
    t_result w_result;

    logic w_in_accept;
    logic w_advance;
    logic [LEVEL_W-1:0] w_level;

    scad_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // The input stage moves on whenever the output register is empty or being drained.
    assign w_advance       = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready   = !r_in_valid || w_advance;
    assign w_in_accept     = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.opcode   <= i_in_ch.opcode;
            r_item.now_time <= i_in_ch.now_time;
            r_item.hash     <= {i_in_ch.hash_word3, i_in_ch.hash_word2,
                                i_in_ch.hash_word1, i_in_ch.hash_word0};
        end
    end

    // Check flags use the level held before this operation.
    logic w_half, w_share, w_meets, w_is_check;

    scad_hash_chk u_hash_chk (
        .i_hash         (r_item.hash),
        .i_target       (w_cfg.target),
        .i_level        (w_level),
        .o_half_share   (w_half),
        .o_share_found  (w_share),
        .o_meets_target (w_meets)
    );

    assign w_is_check = (t_opcode'(r_item.opcode) == OP_CHECK);

    scad_adapt u_adapt (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_advance),
        .i_opcode          (r_item.opcode),
        .i_now             (r_item.now_time),
        .i_share           (w_share),
        .i_cfg             (w_cfg),
        .o_level           (w_level),
        .o_level_now       (w_result.level_now),
        .o_level_change    (w_result.level_change),
        .o_timer_restarted (w_result.timer_restarted)
    );

    // Flags are reported only for check operations.
    assign w_result.half_share   = w_is_check && w_half;
    assign w_result.share_found  = w_is_check && w_share;
    assign w_result.meets_target = w_is_check && w_meets;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.half_share      = r_result.half_share;
    assign o_out_ch.share_found     = r_result.share_found;
    assign o_out_ch.meets_target    = r_result.meets_target;
    assign o_out_ch.level_now       = r_result.level_now;
    assign o_out_ch.level_change    = r_result.level_change;
    assign o_out_ch.timer_restarted = r_result.timer_restarted;
endmodule

>>> tb/sv/tb_share_check_adaptive_difficulty_unit.sv
// Self-checking testbench for the share check and adaptive difficulty unit.
// Depends on scad_pkg, scad_in_if, scad_out_if and the unit itself; needs no files or arguments.
// A directed pass and random phases under several register settings, checked beat by beat.
module tb_share_check_adaptive_difficulty_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scad_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 8;
    localparam int unsigned IDLE_PCT     = 17;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          TAIL_CYCLES  = 10;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          REPORT_MAX   = 10;

    // The opcode field is two bits wide but the package names only three codes.
    localparam logic [1:0]  OP_SPARE     = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;

    scad_in_if  in_ch ();
    scad_out_if out_ch ();

    share_check_adaptive_difficulty_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Operations waiting to be offered on the input channel, and the results
    // predicted for the operations the unit has already accepted.
    t_item   op_queue[$];
    t_result predicted_results[$];

    int  mismatches = 0;
    int  cycles     = 0;
    // While set, neither side idles, so the unit runs at full rate for a while.
    logic steady    = 1'b0;

    // Free-running timestamp source for the random phases.
    logic [TIME_BITS-1:0] wall_clock = '0;

    // Shadow copy of the register file, kept in step with every write.
    logic [HASH_W-1:0]     target_model   = '0;
    logic [LEVEL_W-1:0]    base_model     = BASE_LEVEL_RST;
    logic [INTERVAL_W-1:0] interval_model = SHARE_INTERVAL_RST;
    logic                  adapt_model    = 1'b1;
    logic [TIME_BITS-1:0]  period_model   = ADJUST_PERIOD_RST;

    // Shadow copy of the difficulty state, at its reset values.
    logic [LEVEL_W-1:0]    level_model        = BASE_LEVEL_RST;
    logic [TIME_BITS-1:0]  share_stamp_model  = '0;
    logic [TIME_BITS-1:0]  adjust_stamp_model = '0;

    // Computes the result of one accepted operation and advances the shadow
    // state exactly as the unit must.
    function automatic t_result qualify_and_adapt(input t_item it);
        t_result              r;
        logic [63:0]          top;
        logic [63:0]          zero_mask;
        logic [TIME_BITS-1:0] gap;
        logic [TIME_BITS-1:0] since;
        logic [63:0]          since_w;
        logic [63:0]          ival_w;
        logic [LEVEL_W-1:0]   floor_lvl;
        int                   nbytes;
        r = '0;
        case (it.opcode)
            OP_CHECK: begin
                top = it.hash[HASH_W-1 -: WORD_W];
                // Levels 0, 6 and 7 are taken as they are: one to eight bytes.
                nbytes = int'(level_model) + 1;
                zero_mask = {64{1'b1}} << (64 - 8 * nbytes);
                r.half_share   = (top[63:48] == 16'd0);
                r.share_found  = ((top & zero_mask) == 64'd0);
                // Equality with the target counts as a meet.
                r.meets_target = (it.hash <= target_model);
                if (r.share_found) begin
                    share_stamp_model = it.now_time;
                    r.timer_restarted = 1'b1;
                end
            end
            OP_UPDATE: begin
                // Time differences wrap modulo 2^32.
                gap = it.now_time - adjust_stamp_model;
                if (adapt_model && gap >= period_model) begin
                    since     = it.now_time - share_stamp_model;
                    since_w   = {32'd0, since};
                    ival_w    = {35'd0, interval_model};
                    floor_lvl = (base_model > FLOOR_LEVEL) ? base_model : FLOOR_LEVEL;
                    adjust_stamp_model = it.now_time;
                    if (since_w > 2 * ival_w && level_model > floor_lvl) begin
                        level_model       = level_model - 1'b1;
                        share_stamp_model = it.now_time;
                        r.level_change    = CHG_DOWN;
                        r.timer_restarted = 1'b1;
                    end else if (since_w < ival_w / 3 && level_model < MAX_LEVEL) begin
                        level_model       = level_model + 1'b1;
                        share_stamp_model = it.now_time;
                        r.level_change    = CHG_UP;
                        r.timer_restarted = 1'b1;
                    end
                    // A long silence restarts the timer on its own.
                    if (since_w > 10 * ival_w) begin
                        share_stamp_model = it.now_time;
                        r.timer_restarted = 1'b1;
                    end
                end
            end
            OP_INIT: begin
                share_stamp_model = it.now_time;
                level_model       = base_model;
                r.timer_restarted = 1'b1;
            end
            default: begin
                // The spare opcode leaves everything alone.
            end
        endcase
        r.level_now = level_model;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Clears the top k bytes of a 256-bit value (k from 0 to 8).
    function automatic logic [HASH_W-1:0] zero_top_bytes(input logic [HASH_W-1:0] h,
                                                         input int unsigned k);
        logic [HASH_W-1:0] v;
        v = h;
        v[HASH_W-1 -: WORD_W] = (k >= 8) ? 64'd0 : (h[HASH_W-1 -: WORD_W] >> (8 * k));
        return v;
    endfunction

    // Hash for a check: mostly random with a random run of zero top bytes so
    // that shares at every level occur, sometimes the target itself or the target
    // with one 64-bit word stepped by one so the comparison is tested near its edge.
    function automatic logic [HASH_W-1:0] pick_hash();
        logic [HASH_W-1:0] h;
        int unsigned       m;
        int unsigned       k;
        m = $urandom_range(0, 9);
        h = {rand64(), rand64(), rand64(), rand64()};
        if (m == 0) begin
            h = target_model;
        end else if (m == 1) begin
            h = target_model;
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 1) begin
                h[k * 64 +: 64] = h[k * 64 +: 64] + 64'd1;
            end else begin
                h[k * 64 +: 64] = h[k * 64 +: 64] - 64'd1;
            end
        end else begin
            h = zero_top_bytes(h, $urandom_range(0, 8));
        end
        return h;
    endfunction

    task automatic push_op(input logic [1:0] op, input logic [TIME_BITS-1:0] now,
                           input logic [HASH_W-1:0] hash);
        t_item it;
        it.opcode   = op;
        it.now_time = now;
        it.hash     = hash;
        op_queue.push_back(it);
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    function automatic string fmt_result(input t_result r);
        return $sformatf("half=%0b share=%0b meets=%0b level=%0d change=%0d restart=%0b",
                         r.half_share, r.share_found, r.meets_target, r.level_now,
                         r.level_change, r.timer_restarted);
    endfunction

    // One register write, one per clock edge; the shadow registers follow.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_TARGET0:        target_model[63:0]    = data;
            CFG_TARGET1:        target_model[127:64]  = data;
            CFG_TARGET2:        target_model[191:128] = data;
            CFG_TARGET3:        target_model[255:192] = data;
            CFG_BASE_LEVEL:     base_model            = data[LEVEL_W-1:0];
            CFG_SHARE_INTERVAL: interval_model        = data[INTERVAL_W-1:0];
            CFG_ADAPT_ENABLE:   adapt_model           = data[0];
            CFG_ADJUST_PERIOD:  period_model          = data[TIME_BITS-1:0];
            default: ;
        endcase
    endtask

    // Rewrites every register. Only called while the unit is idle; write enable
    // then drops and the task waits so that any derived values inside settle.
    task automatic apply_settings(input logic [HASH_W-1:0] tgt, input logic [LEVEL_W-1:0] base,
                                  input logic [INTERVAL_W-1:0] ival, input logic en,
                                  input logic [TIME_BITS-1:0] period);
        reg_write(CFG_TARGET0, tgt[63:0]);
        reg_write(CFG_TARGET1, tgt[127:64]);
        reg_write(CFG_TARGET2, tgt[191:128]);
        reg_write(CFG_TARGET3, tgt[255:192]);
        reg_write(CFG_BASE_LEVEL, {61'd0, base});
        reg_write(CFG_SHARE_INTERVAL, {35'd0, ival});
        reg_write(CFG_ADAPT_ENABLE, {63'd0, en});
        reg_write(CFG_ADJUST_PERIOD, {32'd0, period});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    // Waits until every queued operation has been accepted and every
    // predicted result has arrived, then lets the pipeline go quiet.
    task automatic wait_drained();
        while (op_queue.size() != 0 || predicted_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random operations on a moving clock. The clock steps are scaled to the
    // share interval so that updates land in the fast, normal, slow and very
    // slow windows; now and then the clock jumps anywhere, wrap included.
    task automatic run_random_ops(input int unsigned count, input logic [31:0] scale);
        int unsigned       r;
        int unsigned       s;
        logic [63:0]       step;
        logic [63:0]       scale_w;
        logic [1:0]        op;
        logic [HASH_W-1:0] h;
        scale_w = {32'd0, scale};
        repeat (count) begin
            s = $urandom_range(0, 99);
            if (s < 40) begin
                step = scale_w * $urandom_range(0, 100) / 400;
            end else if (s < 70) begin
                step = scale_w * $urandom_range(0, 200) / 100;
            end else if (s < 85) begin
                step = scale_w * $urandom_range(200, 400) / 100;
            end else if (s < 93) begin
                step = scale_w * $urandom_range(1000, 1200) / 100;
            end else begin
                step = {32'd0, $urandom};
            end
            wall_clock = wall_clock + step[31:0] + $urandom_range(0, 1);

            r = $urandom_range(0, 99);
            if (r < 55) begin
                op = OP_CHECK;
            end else if (r < 88) begin
                op = OP_UPDATE;
            end else if (r < 94) begin
                op = OP_INIT;
            end else begin
                op = OP_SPARE;
            end
            // Operations other than a check ignore the hash, so it is pure noise.
            h = (op == OP_CHECK) ? pick_hash() : {rand64(), rand64(), rand64(), rand64()};
            push_op(op, wall_clock, h);
        end
    endtask

    // Input driver: offers the oldest pending operation. A beat that has not
    // been taken is held unchanged; otherwise the side may idle at random.
    // The result of an accepted beat is predicted here, in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predicted_results.push_back(qualify_and_adapt(op_queue.pop_front()));
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Stalled beat stays on the bus.
            end else if (op_queue.size() != 0 &&
                         (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_ch.valid      <= 1'b1;
                in_ch.opcode     <= op_queue[0].opcode;
                in_ch.now_time   <= op_queue[0].now_time;
                in_ch.hash_word0 <= op_queue[0].hash[63:0];
                in_ch.hash_word1 <= op_queue[0].hash[127:64];
                in_ch.hash_word2 <= op_queue[0].hash[191:128];
                in_ch.hash_word3 <= op_queue[0].hash[255:192];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: stalls at random and compares each accepted beat with
    // the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if (out_ch.valid && out_ch.ready) begin
                got.half_share      = out_ch.half_share;
                got.share_found     = out_ch.share_found;
                got.meets_target    = out_ch.meets_target;
                got.level_now       = out_ch.level_now;
                got.level_change    = out_ch.level_change;
                got.timer_restarted = out_ch.timer_restarted;
                if (predicted_results.size() == 0) begin
                    note_failure({"result beat with nothing expected: ", fmt_result(got)});
                end else begin
                    want = predicted_results.pop_front();
                    if (got.half_share      !== want.half_share   ||
                        got.share_found     !== want.share_found  ||
                        got.meets_target    !== want.meets_target ||
                        got.level_now       !== want.level_now    ||
                        got.level_change    !== want.level_change ||
                        got.timer_restarted !== want.timer_restarted) begin
                        note_failure({"mismatch: expected ", fmt_result(want),
                                      " got ", fmt_result(got)});
                    end
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : sequencer
        int unsigned       p;
        int unsigned       kind;
        logic [HASH_W-1:0] tgt;
        logic [LEVEL_W-1:0] base;
        logic [31:0]       ival;
        logic [31:0]       period;
        logic              en;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = '0;
        in_ch.now_time   = '0;
        in_ch.hash_word0 = '0;
        in_ch.hash_word1 = '0;
        in_ch.hash_word2 = '0;
        in_ch.hash_word3 = '0;
        out_ch.ready     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass on the reset settings: level 1, zero target, interval
        // and adjust period of 60000, adaptation on.
        // All-zero hash meets a zero target by equality; all-ones hash fails everything.
        push_op(OP_CHECK, 32'd0, '0);
        push_op(OP_CHECK, 32'hFFFF_FFFF, {HASH_W{1'b1}});
        // Exactly two zero top bytes is a share at level 1; one zero byte is not even half.
        push_op(OP_CHECK, 32'd1000, {64'h0000_8000_0000_0000, {192{1'b1}}});
        push_op(OP_CHECK, 32'd1001, {64'h0001_0000_0000_0000, 192'd0});
        // Too soon after the last adjustment, then exactly one adjust period later.
        push_op(OP_UPDATE, 32'd2000, '0);
        push_op(OP_UPDATE, 32'd60000, '0);
        // Share, then an update exactly a third of the interval later: no raise.
        push_op(OP_CHECK, 32'd100000, {64'h0000_00FF_FFFF_FFFF, 192'd5});
        push_op(OP_UPDATE, 32'd120000, '0);
        // Share, then an update inside a third of the interval: the level rises.
        push_op(OP_CHECK, 32'd165000, {64'h0000_0012_3456_789A, 192'd7});
        push_op(OP_UPDATE, 32'd180000, '0);
        push_op(OP_UPDATE, 32'd240000, '0);
        // Slow share rate below the floor: no drop.
        push_op(OP_UPDATE, 32'd400000, '0);
        // More than ten intervals without a share: timer restart only.
        push_op(OP_UPDATE, 32'd1000001, '0);
        push_op(OP_INIT, 32'd1000500, {HASH_W{1'b1}});
        push_op(OP_SPARE, 32'd5, {HASH_W{1'b1}});
        // Timestamps around the wrap of the 32-bit clock.
        push_op(OP_UPDATE, 32'hFFFF_FFFF, '0);
        push_op(OP_UPDATE, 32'd10, '0);
        push_op(OP_CHECK, 32'd20, {64'h0000_0000_0000_0001, 192'd0});
        wait_drained();

        // Extremes: all-ones target, level 0, zero interval, zero adjust period.
        apply_settings({HASH_W{1'b1}}, 3'd0, 29'd0, 1'b1, 32'd0);
        wall_clock = 32'd2000000;
        run_random_ops(150, 32'd50);
        wait_drained();

        // Opposite extremes: zero target, level 7, interval of 400000000 and the longest period.
        apply_settings('0, 3'd7, 29'd400000000, 1'b1, 32'hFFFF_FFFF);
        run_random_ops(100, 32'd400000000);
        wait_drained();

        // Adaptation off, floor above three, interval of one.
        apply_settings({rand64(), rand64(), rand64(), rand64()}, 3'd5, 29'd1, 1'b0, 32'd0);
        run_random_ops(120, 32'd20);
        wait_drained();

        // Random settings; one phase starts just below the clock wrap and one
        // runs with both sides at full rate.
        for (p = 0; p < 6; p++) begin
            kind = $urandom_range(0, 5);
            if (kind == 0) begin
                tgt = '0;
            end else if (kind == 1) begin
                tgt = {HASH_W{1'b1}};
            end else begin
                tgt = zero_top_bytes({rand64(), rand64(), rand64(), rand64()},
                                     $urandom_range(0, 8));
            end
            base   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 5));
            ival   = $urandom_range(3, 3000);
            period = $urandom_range(0, ival);
            en     = ($urandom_range(0, 9) != 0);
            apply_settings(tgt, base, ival[INTERVAL_W-1:0], en, period);
            if (p == 2) begin
                wall_clock = 32'hFFFF_FFFF - $urandom_range(0, 20 * ival);
            end
            steady = (p == 3);
            run_random_ops(230, ival);
            wait_drained();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
